/* hdl/ubh_pkg.sv */
package ubh_pkg;

   // Number of counters in the count memory and the width of each counter.
   localparam int MAX_BINS    = 256;
   localparam int COUNT_WIDTH = 32;

   // Width of one Q16.16 value and of the bin count register.
   localparam int VALUE_W = 32;
   localparam int BINS_W  = 9;

   // Memory address width, and the width that holds a bin count up to MAX_BINS.
   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int NB_W  = $clog2(MAX_BINS + 1);

   // The quotient of the bin division is at most the bin count, so it has NB_W bits.
   localparam int QW     = NB_W;
   localparam int PW     = VALUE_W + NB_W;
   localparam int STEP_W = $clog2(QW);

   localparam int CSR_INDEX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_IN_USE = 2'd2;

   // Transaction kinds.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] sample;
      logic [7:0]         bin_select;
   } req_payload_type;

   typedef struct packed {
      logic        accepted;
      logic [7:0]  bin_number;
      logic [31:0] count_value;
   } rsp_payload_type;

endpackage

/* hdl/uniform_bin_histogram_top.sv */
// Channel   Direction  Handshake              Content
// req_      in         req_valid/req_ready    ubh_pkg::req_payload_type (insert or read)
// rsp_      out        rsp_valid/rsp_ready    ubh_pkg::rsp_payload_type (one per request)
// csr_      in         csr_valid/csr_ready    csr_index, csr_data (register write)
//
// An insert passes through the set-up states PREP and MUL, nine steps of the restoring
// divider, then a read, modify and write of the count memory; one out of range ends after PREP.
// A read passes through memory lookup, result and reply; a bin past the bin count skips the lookup.
// After reset the count memory is swept to zero, one entry a cycle, over all MAX_BINS entries;
// req_ready stays low meanwhile while register writes are taken as ever.
// A stalled result waits in the output register while the next request is accepted.
module uniform_bin_histogram_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ubh_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ubh_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ubh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_data
);

   // One-hot sequencer states.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CLEAR  = 7'b0000010,
      ST_PREP   = 7'b0000100,
      ST_MUL    = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_LOOKUP = 7'b0100000,
      ST_UPDATE = 7'b1000000
   } state_type;

   // The reply state shares the idle encoding space poorly, so it gets its own flag.
   state_type state_ff, state_in;
   logic      reply_ff;

   // Configuration registers.
   logic signed [ubh_pkg::VALUE_W-1:0] range_low_ff;
   logic signed [ubh_pkg::VALUE_W-1:0] range_high_ff;
   logic [ubh_pkg::BINS_W-1:0]         bins_in_use_ff;

   // Per-transaction registers.
   logic                               kind_ff;
   logic signed [ubh_pkg::VALUE_W-1:0] sample_ff;
   logic [ubh_pkg::VALUE_W-1:0]        diff_ff;
   logic [ubh_pkg::VALUE_W-1:0]        span_ff;
   logic [ubh_pkg::PW-1:0]             rem_ff;
   logic [ubh_pkg::PW-1:0]             trial_ff;
   logic [ubh_pkg::QW-1:0]             quot_ff;
   logic [ubh_pkg::STEP_W-1:0]         step_ff;
   logic [ubh_pkg::BIN_W-1:0]          idx_ff;
   logic [ubh_pkg::BIN_W-1:0]          clr_ff;
   ubh_pkg::rsp_payload_type           res_ff;

   // Output register.
   logic                               rsp_valid_ff;
   ubh_pkg::rsp_payload_type           rsp_payload_ff;

   // Count memory with a registered read port.
   logic [ubh_pkg::COUNT_WIDTH-1:0]    count_mem [ubh_pkg::MAX_BINS];
   logic [ubh_pkg::COUNT_WIDTH-1:0]    rd_data_ff;
   logic                               mem_we;
   logic [ubh_pkg::BIN_W-1:0]          mem_wa;
   logic [ubh_pkg::COUNT_WIDTH-1:0]    mem_wd;

   // Derived values.
   logic [ubh_pkg::NB_W-1:0]           bins_eff;
   logic signed [ubh_pkg::VALUE_W:0]   diff_wide;
   logic signed [ubh_pkg::VALUE_W:0]   span_wide;
   logic                               in_range;
   logic [ubh_pkg::PW-1:0]             product;
   logic                               trial_fits;
   logic [ubh_pkg::QW-1:0]             quot_next;
   logic [ubh_pkg::QW-1:0]             quot_clamped;
   logic [ubh_pkg::COUNT_WIDTH-1:0]    count_next;
   logic                               req_fire;
   logic                               rsp_slot_free;
   logic                               sel_valid;

   assign req_ready     = (state_ff == ST_IDLE) && !reply_ff;
   assign csr_ready     = 1'b1;
   assign req_fire      = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_payload_ff;
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   // A bin count above the memory depth uses the whole memory.
   always_comb begin
      if (32'(bins_in_use_ff) > 32'(ubh_pkg::MAX_BINS)) begin
         bins_eff = ubh_pkg::NB_W'(ubh_pkg::MAX_BINS);
      end else begin
         bins_eff = ubh_pkg::NB_W'(bins_in_use_ff);
      end
   end

   assign sel_valid = 32'(req_payload.bin_select) < 32'(bins_eff);

   // Range check and offsets, in 33-bit signed arithmetic so nothing wraps.
   assign diff_wide = {sample_ff[ubh_pkg::VALUE_W-1], sample_ff}
                      - {range_low_ff[ubh_pkg::VALUE_W-1], range_low_ff};
   assign span_wide = {range_high_ff[ubh_pkg::VALUE_W-1], range_high_ff}
                      - {range_low_ff[ubh_pkg::VALUE_W-1], range_low_ff};
   assign in_range  = (bins_eff != '0) && (span_wide > 0) && !diff_wide[ubh_pkg::VALUE_W]
                      && (sample_ff <= range_high_ff);

   assign product = diff_ff * bins_eff;

   // One restoring division step: the quotient is shifted in from the top bit down.
   assign trial_fits = rem_ff >= trial_ff;
   assign quot_next  = {quot_ff[ubh_pkg::QW-2:0], trial_fits};

   // A sample on the upper bound gives a quotient equal to the bin count; it joins the
   // last bin.
   assign quot_clamped = (quot_next >= bins_eff) ? (bins_eff - 1'b1) : quot_next;

   // Counters saturate at all ones.
   assign count_next = (&rd_data_ff) ? rd_data_ff : rd_data_ff + 1'b1;

   // Memory write port: zero during the sweep after reset, the new count on an insert.
   assign mem_we = (state_ff == ST_CLEAR)
                   || ((state_ff == ST_UPDATE) && (kind_ff == ubh_pkg::KIND_INSERT));
   assign mem_wa = (state_ff == ST_CLEAR) ? clr_ff : idx_ff;
   assign mem_wd = (state_ff == ST_CLEAR) ? '0 : count_next;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= count_mem[idx_ff];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ubh_pkg::BIN_W'(ubh_pkg::MAX_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (req_payload.kind == ubh_pkg::KIND_INSERT)) begin
               state_in = ST_PREP;
            end else if (req_fire && sel_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_PREP: begin
            state_in = in_range ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         reply_ff       <= 1'b0;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         range_low_ff   <= '0;
         range_high_ff  <= 32'sd65536;
         bins_in_use_ff <= ubh_pkg::BINS_W'(1);
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end

         // The reply flag is set whenever a result has been formed and holds the
         // sequencer until the output register takes it.
         if (reply_ff && rsp_slot_free) begin
            reply_ff <= 1'b0;
         end else if ((state_ff == ST_UPDATE)
                      || ((state_ff == ST_PREP) && !in_range)
                      || ((state_ff == ST_IDLE) && req_fire
                          && (req_payload.kind == ubh_pkg::KIND_READ) && !sel_valid)) begin
            reply_ff <= 1'b1;
         end

         if (reply_ff && rsp_slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid) begin
            case (csr_index)
               ubh_pkg::CSR_RANGE_LOW:   range_low_ff   <= csr_data;
               ubh_pkg::CSR_RANGE_HIGH:  range_high_ff  <= csr_data;
               ubh_pkg::CSR_BINS_IN_USE: bins_in_use_ff <= csr_data[ubh_pkg::BINS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (reply_ff && rsp_slot_free) begin
         rsp_payload_ff <= res_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_ff   <= req_payload.kind;
               sample_ff <= req_payload.sample;
               idx_ff    <= ubh_pkg::BIN_W'(req_payload.bin_select);
               res_ff    <= '{accepted: 1'b0, bin_number: req_payload.bin_select,
                              count_value: '0};
            end
         end
         ST_PREP: begin
            diff_ff <= diff_wide[ubh_pkg::VALUE_W-1:0];
            span_ff <= span_wide[ubh_pkg::VALUE_W-1:0];
            res_ff  <= '{accepted: 1'b0, bin_number: 8'd0, count_value: '0};
         end
         ST_MUL: begin
            rem_ff   <= product;
            trial_ff <= ubh_pkg::PW'(span_ff) << (ubh_pkg::QW - 1);
            quot_ff  <= '0;
            step_ff  <= ubh_pkg::STEP_W'(ubh_pkg::QW - 1);
         end
         ST_DIV: begin
            if (trial_fits) begin
               rem_ff <= rem_ff - trial_ff;
            end
            trial_ff <= trial_ff >> 1;
            quot_ff  <= quot_next;
            step_ff  <= step_ff - 1'b1;
            if (step_ff == '0) begin
               idx_ff <= ubh_pkg::BIN_W'(quot_clamped);
            end
         end
         ST_UPDATE: begin
            res_ff.accepted   <= 1'b1;
            res_ff.bin_number <= 8'(idx_ff);
            if (kind_ff == ubh_pkg::KIND_INSERT) begin
               res_ff.count_value <= 32'(count_next);
            end else begin
               res_ff.count_value <= 32'(rd_data_ff);
            end
         end
         default: ;
      endcase
   end

   // A request holds the sequencer, so the next cycle never accepts another.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while the previous one is still in progress");

   // A fresh result appears only when a formed result leaves the reply stage.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(reply_ff))
      else $error("result appeared without a formed reply");

   // An insert only ever touches a bin below the active bin count.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPDATE) && (kind_ff == ubh_pkg::KIND_INSERT))
      |-> (32'(idx_ff) < 32'(bins_eff)))
      else $error("insert addressed a bin beyond the bin count");

   // The reply stage and a busy sequencer never overlap.
   assert property (@(posedge clock) disable iff (reset)
      reply_ff |-> (state_ff == ST_IDLE))
      else $error("reply pending while the sequencer is busy");

endmodule
